// File: rtl/bhrs_pkg.sv
package bhrs_pkg;

  // Page store geometry
  localparam int PAGE_COUNT  = 32;
  localparam int PAGE_BYTES  = 7;
  localparam int SINGLE_KEYS = 6;

  localparam int PAGE_AW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SLOT_W   = 3;
  localparam int ROW_W    = PAGE_BYTES * 8;
  localparam int KEY_W    = 48;
  localparam int PAGE_NUM_W = 5;
  localparam int POS_W    = 6;
  localparam int PFX_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_PAGE_WR = 2'd2
  } cmd_t;

  // Report kinds; the automatic request shares the code of no report
  typedef enum logic [1:0] {
    REP_NONE = 2'd0,
    REP_KBD  = 2'd1,
    REP_JOY  = 2'd2
  } rep_t;

  localparam logic [1:0] ASK_AUTO = 2'd0;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_JOY    = 2'd1,
    MODE_SINGLE = 2'd2,
    MODE_SEQ    = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SK_MODS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SK_CODES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd5;

  // One byte write into the page store
  typedef struct packed {
    logic               en;
    logic [PAGE_AW-1:0] page;
    logic [SLOT_W-1:0]  slot;
    logic [7:0]         value;
  } page_wr_t;

endpackage

// File: rtl/bhrs_page_store.sv
module bhrs_page_store (
  input  logic                          clk,
  input  logic                          rst,
  input  bhrs_pkg::page_wr_t            wr,
  input  logic [bhrs_pkg::PAGE_AW-1:0]  rd_addr,
  output logic [bhrs_pkg::ROW_W-1:0]    cur_row,
  output logic [bhrs_pkg::ROW_W-1:0]    row0
);
  import bhrs_pkg::*;

  logic [ROW_W-1:0]      mem [PAGE_COUNT];
  logic [ROW_W-1:0]      row_q;
  logic [PAGE_BYTES-1:0] vld [PAGE_COUNT];
  logic [PAGE_AW-1:0]    cur_addr;
  logic                  byp_hit;
  logic [SLOT_W-1:0]     byp_slot;
  logic [7:0]            byp_value;

  // Row memory, one byte lane written per item; prefetch read of the next row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.page][wr.slot*8 +: 8] <= wr.value;
    end
    row_q <= mem[rd_addr];
  end

  // Per-byte valid bits and the bypass for a write that missed the prefetch
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        vld[i] <= '0;
      end
      byp_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.page][wr.slot] <= 1'b1;
      end
      byp_hit <= wr.en && (wr.page == rd_addr);
    end
    cur_addr  <= rd_addr;
    byp_slot  <= wr.slot;
    byp_value <= wr.value;
  end

  // Page 0 copy in flops, needed in the same cycle a sequence starts
  always_ff @(posedge clk) begin
    if (rst) begin
      row0 <= '0;
    end else if (wr.en && (wr.page == '0)) begin
      row0[wr.slot*8 +: 8] <= wr.value;
    end
  end

  // Current row: unwritten bytes read as zero
  always_comb begin
    for (int k = 0; k < PAGE_BYTES; k++) begin
      if (!vld[cur_addr][k]) begin
        cur_row[k*8 +: 8] = 8'h00;
      end else if (byp_hit && (byp_slot == SLOT_W'(k))) begin
        cur_row[k*8 +: 8] = byp_value;
      end else begin
        cur_row[k*8 +: 8] = row_q[k*8 +: 8];
      end
    end
  end

endmodule

// File: rtl/button_hid_report_sequencer.sv
// Channel   Direction  Handshake            Content
// in        to block   in_valid/in_ready    command, pin_level, asked_report, page_number,
//                                           byte_slot, byte_value
// out       from block out_valid/out_ready  report_kind, modifier_byte, key_bytes, joy_button,
//                                           debounced
// cfg       to block   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while the output is not stalled; a taken item passes the input
// register, then the result register, on its way to the output.
// Each item is worked in one pass between the input and result registers; the page row is
// prefetched from the row memory into a read register, with a bypass for the latest write.
// Reset clears all state, sets configuration to defaults and clears the page valid bits at once.
// A stalled output holds the result register; the input register refills as soon as it moves.
module button_hid_report_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic                              pin_level,
  input  logic [1:0]                        asked_report,
  input  logic [bhrs_pkg::PAGE_NUM_W-1:0]   page_number,
  input  logic [bhrs_pkg::SLOT_W-1:0]       byte_slot,
  input  logic [7:0]                        byte_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        report_kind,
  output logic [7:0]                        modifier_byte,
  output logic [bhrs_pkg::KEY_W-1:0]        key_bytes,
  output logic                              joy_button,
  output logic                              debounced,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bhrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bhrs_pkg::*;

  // Configuration
  mode_t             mode;
  logic [7:0]        single_key_mods;
  logic [KEY_W-1:0]  single_key_codes;
  logic [POS_W-1:0]  sequence_length;
  logic [7:0]        lockout_ticks;
  logic              pin_active_low;

  // Input register
  logic                  s1_valid;
  logic [1:0]            s1_command;
  logic                  s1_pin;
  logic [1:0]            s1_asked;
  logic [PAGE_NUM_W-1:0] s1_page;
  logic [SLOT_W-1:0]     s1_slot;
  logic [7:0]            s1_value;
  logic                  s1_fire;

  // Block state
  logic             lock_active, lock_active_next;
  logic [7:0]       lock_count, lock_count_next;
  logic             held_level, held_level_next;
  logic             next_is_joy, next_is_joy_next;
  logic             press_latched, press_latched_next;
  logic             seq_running, seq_running_next;
  logic             seq_release_phase, seq_release_phase_next;
  logic [POS_W-1:0] seq_position, seq_position_next;
  logic [PFX_W-1:0] prefix_count, prefix_count_next;

  // Result of the current item
  logic [1:0]       res_kind;
  logic [7:0]       res_mods;
  logic [KEY_W-1:0] res_keys;
  logic             res_joy;

  page_wr_t         pwr;
  logic [POS_W-1:0] pos_upd;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] row0;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_JOY;
      single_key_mods  <= 8'd0;
      single_key_codes <= KEY_W'(44);
      sequence_length  <= '0;
      lockout_ticks    <= 8'd10;
      pin_active_low   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:       mode             <= mode_t'(cfg_data[1:0]);
        CFG_SK_MODS:    single_key_mods  <= cfg_data[7:0];
        CFG_SK_CODES:   single_key_codes <= cfg_data[KEY_W-1:0];
        CFG_SEQ_LEN:    sequence_length  <= cfg_data[POS_W-1:0];
        CFG_LOCKOUT:    lockout_ticks    <= cfg_data[7:0];
        CFG_ACTIVE_LOW: pin_active_low   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_command <= command;
      s1_pin     <= pin_level;
      s1_asked   <= asked_report;
      s1_page    <= page_number;
      s1_slot    <= byte_slot;
      s1_value   <= byte_value;
    end
  end

  // Item processing
  always_comb begin
    logic [8:0]       lock_nxt;
    logic             pressed;
    logic [1:0]       asked;
    logic             starting;
    logic [ROW_W-1:0] row;
    logic             row_oor;
    logic [PFX_W-1:0] pfx_inc;

    lock_active_next       = lock_active;
    lock_count_next        = lock_count;
    held_level_next        = held_level;
    next_is_joy_next       = next_is_joy;
    press_latched_next     = press_latched;
    seq_running_next       = seq_running;
    seq_release_phase_next = seq_release_phase;
    seq_position_next      = seq_position;
    prefix_count_next      = prefix_count;
    res_kind = REP_NONE;
    res_mods = '0;
    res_keys = '0;
    res_joy  = 1'b0;
    pwr      = '0;
    lock_nxt = {1'b0, lock_count} + 9'd1;
    pressed  = pin_active_low ? !s1_pin : s1_pin;
    asked    = s1_asked;
    starting = 1'b0;
    row      = cur_row;
    row_oor  = 1'b0;
    pfx_inc  = prefix_count + PFX_W'(1);

    case (cmd_t'(s1_command))
      CMD_TICK: begin
        if (lock_active) begin
          if (lock_nxt > {1'b0, lockout_ticks}) begin
            lock_active_next = 1'b0;
          end
          lock_count_next = lock_nxt[7:0];
        end
      end
      CMD_REPORT: begin
        // Debounce: take a new level only while unlocked
        if (!lock_active && (pressed != held_level)) begin
          lock_active_next = 1'b1;
          lock_count_next  = '0;
          held_level_next  = pressed;
        end
        if (asked == ASK_AUTO) begin
          asked            = next_is_joy ? REP_JOY : REP_KBD;
          next_is_joy_next = !next_is_joy;
        end
        if (asked == REP_KBD) begin
          res_kind = REP_KBD;
          if (mode == MODE_SEQ) begin
            // Key sequence: arm on a press edge, then press/empty per page
            if (!seq_running) begin
              if (press_latched && !held_level_next) begin
                press_latched_next = 1'b0;
              end
              if (held_level_next && !press_latched_next) begin
                press_latched_next     = 1'b1;
                seq_running_next       = 1'b1;
                seq_release_phase_next = 1'b0;
                seq_position_next      = '0;
                starting               = 1'b1;
              end
            end
            row     = starting ? row0 : cur_row;
            row_oor = !starting && (seq_position >= POS_W'(PAGE_COUNT));
            if (seq_running_next) begin
              if (!seq_release_phase_next) begin
                if (!row_oor) begin
                  res_mods = row[7:0];
                  for (int k = 1; k < PAGE_BYTES; k++) begin
                    if (k <= 6) begin
                      res_keys[(k-1)*8 +: 8] = row[k*8 +: 8];
                    end
                  end
                end
                seq_release_phase_next = 1'b1;
              end else begin
                seq_position_next      = seq_position + POS_W'(1);
                seq_release_phase_next = 1'b0;
                if (seq_position_next >= sequence_length) begin
                  seq_running_next = 1'b0;
                end
              end
            end
          end else if (mode == MODE_SINGLE) begin
            // Single key: growing prefix of the configured codes while held
            if (held_level_next) begin
              res_mods = single_key_mods;
              for (int k = 0; k < SINGLE_KEYS; k++) begin
                if (PFX_W'(k) < prefix_count) begin
                  res_keys[k*8 +: 8] = single_key_codes[k*8 +: 8];
                end
              end
              if (pfx_inc >= PFX_W'(SINGLE_KEYS)) begin
                prefix_count_next = PFX_W'(SINGLE_KEYS - 1);
              end else begin
                prefix_count_next = pfx_inc;
              end
            end else begin
              prefix_count_next = '0;
            end
          end
        end else if (asked == REP_JOY) begin
          res_kind = REP_JOY;
          if (mode == MODE_JOY) begin
            res_joy = held_level_next;
          end
        end
      end
      CMD_PAGE_WR: begin
        if ((int'(s1_page) < PAGE_COUNT) && (s1_slot < SLOT_W'(PAGE_BYTES))) begin
          pwr.en    = s1_fire;
          pwr.page  = PAGE_AW'(s1_page);
          pwr.slot  = s1_slot;
          pwr.value = s1_value;
        end
      end
      default: ;
    endcase
  end

  // Row prefetch follows the position left by this cycle
  assign pos_upd = s1_fire ? seq_position_next : seq_position;

  bhrs_page_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (pwr),
    .rd_addr (PAGE_AW'(pos_upd)),
    .cur_row (cur_row),
    .row0    (row0)
  );

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_active       <= 1'b0;
      lock_count        <= '0;
      held_level        <= 1'b0;
      next_is_joy       <= 1'b0;
      press_latched     <= 1'b0;
      seq_running       <= 1'b0;
      seq_release_phase <= 1'b0;
      seq_position      <= '0;
      prefix_count      <= '0;
    end else if (s1_fire) begin
      lock_active       <= lock_active_next;
      lock_count        <= lock_count_next;
      held_level        <= held_level_next;
      next_is_joy       <= next_is_joy_next;
      press_latched     <= press_latched_next;
      seq_running       <= seq_running_next;
      seq_release_phase <= seq_release_phase_next;
      seq_position      <= seq_position_next;
      prefix_count      <= prefix_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      report_kind   <= res_kind;
      modifier_byte <= res_mods;
      key_bytes     <= res_keys;
      joy_button    <= res_joy;
      debounced     <= held_level_next;
    end
  end

  // Checks
  a_release_needs_run: assert property (@(posedge clk) disable iff (rst)
    seq_release_phase |-> seq_running)
    else $error("release phase without a running sequence");

  a_prefix_cap: assert property (@(posedge clk) disable iff (rst)
    prefix_count <= PFX_W'(SINGLE_KEYS - 1))
    else $error("single-key prefix above cap");

  a_no_report_kind: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1_command != CMD_REPORT) |=> out_valid && (report_kind == REP_NONE))
    else $error("report produced for a non-report item");

  a_joy_only_in_joy: assert property (@(posedge clk) disable iff (rst)
    out_valid && joy_button |-> report_kind == REP_JOY)
    else $error("joystick bit outside a joystick report");

endmodule
